@@ design/ffsa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffsa_pkg
// Shared types and constants for the first-fit segment allocator.
// ----------------------------------------------------------------------------
package ffsa_pkg;

	localparam int NUM_SEGMENTS_DEF  = 256;
	localparam int SEGMENT_BYTES_DEF = 4096;

	localparam int ADDR_W      = 32;
	localparam int REQ_BYTES_W = 21;
	localparam int SEG_COUNT_W = 9;
	localparam int STATUS_W    = 2;
	localparam int CFG_INDEX_W = 1;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_SPACE  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;

	localparam logic MODE_ALLOC   = 1'b0;
	localparam logic MODE_RELEASE = 1'b1;

	localparam logic [CFG_INDEX_W-1:0] REG_DATA_BASE     = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_SEGMENT_COUNT = 1'd1;

	localparam logic [ADDR_W-1:0]      DATA_BASE_RST     = '0;
	localparam logic [SEG_COUNT_W-1:0] SEG_COUNT_RST     = 9'd256;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_MARK,
		S_FIND,
		S_WALK,
		S_RESP
	} state_t;

endpackage

@@ design/first_fit_segment_allocator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_segment_allocator
// First-fit allocator over a table of equal-sized segments.
//
// Request channel (in_valid/in_ready): mode 0 allocates request_bytes, mode 1
// releases the run starting at release_address. Every request gives exactly
// one result on the out channel (block_address, status).
// Config channel (cfg_valid/cfg_ready, always ready): index 0 data_base,
// index 1 segment_count. Write only while no request is in flight.
// An allocate reads one used flag a cycle; a miss gives no_space, a hit
// marks its run one segment a cycle. A release compares one segment
// address a cycle: not_found if none of the active segments matches,
// otherwise it clears one segment a cycle up to the run end (or the last
// segment). A zero segment count answers without a scan. One request is
// in flight at a time; in_ready rises with the result.
// Reset: both flag memories are swept to zero, one entry a cycle, over
// every entry; in_ready stays low meanwhile.
// Output is registered: a new request is taken while a result waits; if the
// receiver stalls, the next result holds until the output register frees.
// ----------------------------------------------------------------------------
module first_fit_segment_allocator #(
	parameter int NUM_SEGMENTS  = ffsa_pkg::NUM_SEGMENTS_DEF,
	parameter int SEGMENT_BYTES = ffsa_pkg::SEGMENT_BYTES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               mode,
	input  logic [ffsa_pkg::REQ_BYTES_W-1:0]   request_bytes,
	input  logic [ffsa_pkg::ADDR_W-1:0]        release_address,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [ffsa_pkg::ADDR_W-1:0]        block_address,
	output logic [ffsa_pkg::STATUS_W-1:0]      status,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ffsa_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [ffsa_pkg::ADDR_W-1:0]        cfg_data
);

	localparam int IDX_W = $clog2(NUM_SEGMENTS);
	localparam int CNT_W = $clog2(NUM_SEGMENTS + 1);
	localparam int CMP_W = (CNT_W > ffsa_pkg::SEG_COUNT_W) ? CNT_W : ffsa_pkg::SEG_COUNT_W;
	localparam int CAP_W = $clog2((2 ** ffsa_pkg::REQ_BYTES_W) + SEGMENT_BYTES);
	localparam int AW    = ffsa_pkg::ADDR_W;

	localparam logic [AW-1:0]    SEG_STEP = AW'(SEGMENT_BYTES);
	localparam logic [CAP_W-1:0] CAP_STEP = CAP_W'(SEGMENT_BYTES);
	localparam logic [CMP_W-1:0] NUM_CMP  = CMP_W'(NUM_SEGMENTS);
	localparam logic [CNT_W-1:0] NUM_LAST = CNT_W'(NUM_SEGMENTS - 1);

	ffsa_pkg::state_t state_q, state_d;

	// configuration
	logic [AW-1:0]                      data_base_q;
	logic [ffsa_pkg::SEG_COUNT_W-1:0]   seg_count_q;

	// request context
	logic [CAP_W-1:0] bytes_q;
	logic [AW-1:0]    addr_q;
	logic [CNT_W-1:0] last_q;
	logic [CNT_W-1:0] issue_q;
	logic             pend_s1;
	logic [CNT_W-1:0] chk_s1;
	logic [AW-1:0]    seg_addr_q;
	logic             in_run_q;
	logic [CAP_W-1:0] cap_q;
	logic [AW-1:0]    start_addr_q;
	logic [CNT_W-1:0] end_q;
	logic [CNT_W-1:0] mk_q;
	logic [CNT_W-1:0] clr_q;
	logic [AW-1:0]                   res_addr_q;
	logic [ffsa_pkg::STATUS_W-1:0]   res_status_q;

	// output register
	logic                            out_valid_q;
	logic [AW-1:0]                   block_address_q;
	logic [ffsa_pkg::STATUS_W-1:0]   status_q;

	// memory ports
	logic             used_we, used_wdata, used_re, used_rdata;
	logic [IDX_W-1:0] used_waddr, used_raddr;
	logic             rend_we, rend_wdata, rend_re, rend_rdata;
	logic [IDX_W-1:0] rend_waddr, rend_raddr;

	logic             accept;
	logic [CMP_W-1:0] seg_cnt_ext;
	logic [CNT_W-1:0] active_cnt;
	logic             issue_ok;
	logic [CAP_W-1:0] run_cap;
	logic             scan_hit, scan_last, find_match, find_last, walk_done, out_free;
	logic             res_load;
	logic [AW-1:0]                   res_addr_d;
	logic [ffsa_pkg::STATUS_W-1:0]   res_status_d;

	ffsa_flag_ram #(.DEPTH(NUM_SEGMENTS)) u_used (
		.clk   (clk),
		.we    (used_we),
		.waddr (used_waddr),
		.wdata (used_wdata),
		.re    (used_re),
		.raddr (used_raddr),
		.rdata (used_rdata)
	);

	ffsa_flag_ram #(.DEPTH(NUM_SEGMENTS)) u_run_end (
		.clk   (clk),
		.we    (rend_we),
		.waddr (rend_waddr),
		.wdata (rend_wdata),
		.re    (rend_re),
		.raddr (rend_raddr),
		.rdata (rend_rdata)
	);

	assign accept      = in_valid && in_ready;
	assign seg_cnt_ext = CMP_W'(seg_count_q);
	assign active_cnt  = (seg_cnt_ext > NUM_CMP) ? CNT_W'(NUM_SEGMENTS) : CNT_W'(seg_cnt_ext);
	assign issue_ok    = issue_q <= last_q;
	assign out_free    = !out_valid_q || out_ready;

	// scan: capacity of the free run including the segment being checked
	assign run_cap    = (in_run_q ? cap_q : '0) + CAP_STEP;
	assign scan_hit   = pend_s1 && !used_rdata && (run_cap >= bytes_q);
	assign scan_last  = pend_s1 && (chk_s1 == last_q);
	assign find_match = seg_addr_q == addr_q;
	assign find_last  = issue_q == last_q;
	assign walk_done  = pend_s1 && (rend_rdata || (chk_s1 == last_q));

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ffsa_pkg::S_CLEAR: begin
				if (clr_q == NUM_LAST) state_d = ffsa_pkg::S_IDLE;
			end
			ffsa_pkg::S_IDLE: begin
				if (accept) begin
					if (active_cnt == '0) state_d = ffsa_pkg::S_RESP;
					else if (mode == ffsa_pkg::MODE_ALLOC) state_d = ffsa_pkg::S_SCAN;
					else state_d = ffsa_pkg::S_FIND;
				end
			end
			ffsa_pkg::S_SCAN: begin
				if (scan_hit) state_d = ffsa_pkg::S_MARK;
				else if (scan_last) state_d = ffsa_pkg::S_RESP;
			end
			ffsa_pkg::S_MARK: begin
				if (mk_q == end_q) state_d = ffsa_pkg::S_RESP;
			end
			ffsa_pkg::S_FIND: begin
				if (find_match) state_d = ffsa_pkg::S_WALK;
				else if (find_last) state_d = ffsa_pkg::S_RESP;
			end
			ffsa_pkg::S_WALK: begin
				if (walk_done) state_d = ffsa_pkg::S_RESP;
			end
			ffsa_pkg::S_RESP: begin
				if (out_free) state_d = ffsa_pkg::S_IDLE;
			end
			default: state_d = ffsa_pkg::S_IDLE;
		endcase
	end

	// memory control and result capture
	always_comb begin
		used_we      = 1'b0;
		used_waddr   = chk_s1[IDX_W-1:0];
		used_wdata   = 1'b0;
		used_re      = 1'b0;
		used_raddr   = issue_q[IDX_W-1:0];
		rend_we      = 1'b0;
		rend_waddr   = chk_s1[IDX_W-1:0];
		rend_wdata   = 1'b0;
		rend_re      = 1'b0;
		rend_raddr   = issue_q[IDX_W-1:0];
		res_load     = 1'b0;
		res_addr_d   = '0;
		res_status_d = ffsa_pkg::ST_OK;
		case (state_q)
			ffsa_pkg::S_CLEAR: begin
				used_we    = 1'b1;
				used_waddr = clr_q[IDX_W-1:0];
				rend_we    = 1'b1;
				rend_waddr = clr_q[IDX_W-1:0];
			end
			ffsa_pkg::S_IDLE: begin
				if (accept && active_cnt == '0) begin
					res_load     = 1'b1;
					res_status_d = (mode == ffsa_pkg::MODE_ALLOC) ?
						ffsa_pkg::ST_NO_SPACE : ffsa_pkg::ST_NOT_FOUND;
				end
			end
			ffsa_pkg::S_SCAN: begin
				used_re = issue_ok;
				if (scan_hit) begin
					res_load   = 1'b1;
					res_addr_d = in_run_q ? start_addr_q : seg_addr_q;
				end else if (scan_last) begin
					res_load     = 1'b1;
					res_status_d = ffsa_pkg::ST_NO_SPACE;
				end
			end
			ffsa_pkg::S_MARK: begin
				used_we    = 1'b1;
				used_waddr = mk_q[IDX_W-1:0];
				used_wdata = 1'b1;
				if (mk_q == end_q) begin
					rend_we    = 1'b1;
					rend_waddr = end_q[IDX_W-1:0];
					rend_wdata = 1'b1;
				end
			end
			ffsa_pkg::S_FIND: begin
				if (!find_match && find_last) begin
					res_load     = 1'b1;
					res_status_d = ffsa_pkg::ST_NOT_FOUND;
				end
			end
			ffsa_pkg::S_WALK: begin
				rend_re = issue_ok && !walk_done;
				if (pend_s1) begin
					used_we = 1'b1;
					rend_we = rend_rdata;
				end
				if (walk_done) res_load = 1'b1;
			end
			ffsa_pkg::S_RESP: begin
			end
			default: begin
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ffsa_pkg::S_CLEAR;
			clr_q       <= '0;
			pend_s1     <= 1'b0;
			issue_q     <= '0;
			out_valid_q <= 1'b0;
			data_base_q <= ffsa_pkg::DATA_BASE_RST;
			seg_count_q <= ffsa_pkg::SEG_COUNT_RST;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					ffsa_pkg::REG_DATA_BASE:     data_base_q <= cfg_data;
					ffsa_pkg::REG_SEGMENT_COUNT: seg_count_q <= cfg_data[ffsa_pkg::SEG_COUNT_W-1:0];
					default: begin
					end
				endcase
			end
			case (state_q)
				ffsa_pkg::S_CLEAR: clr_q <= CNT_W'(clr_q + 1'b1);
				ffsa_pkg::S_IDLE: begin
					issue_q <= '0;
					pend_s1 <= 1'b0;
				end
				ffsa_pkg::S_SCAN, ffsa_pkg::S_WALK: begin
					pend_s1 <= (state_q == ffsa_pkg::S_SCAN) ? used_re : rend_re;
					if ((state_q == ffsa_pkg::S_SCAN) ? used_re : rend_re) begin
						issue_q <= CNT_W'(issue_q + 1'b1);
					end
				end
				ffsa_pkg::S_FIND: begin
					pend_s1 <= 1'b0;
					if (!find_match) issue_q <= CNT_W'(issue_q + 1'b1);
				end
				default: begin
				end
			endcase
			if (state_q == ffsa_pkg::S_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (res_load) begin
			res_addr_q   <= res_addr_d;
			res_status_q <= res_status_d;
		end
		if (state_q == ffsa_pkg::S_RESP && out_free) begin
			block_address_q <= res_addr_q;
			status_q        <= res_status_q;
		end
		chk_s1 <= issue_q;
		case (state_q)
			ffsa_pkg::S_IDLE: begin
				bytes_q    <= CAP_W'(request_bytes);
				addr_q     <= release_address;
				last_q     <= CNT_W'(active_cnt - 1'b1);
				seg_addr_q <= data_base_q;
				in_run_q   <= 1'b0;
				cap_q      <= '0;
			end
			ffsa_pkg::S_SCAN: begin
				if (pend_s1) begin
					seg_addr_q <= seg_addr_q + SEG_STEP;
					if (used_rdata) begin
						in_run_q <= 1'b0;
					end else begin
						if (!in_run_q) start_addr_q <= seg_addr_q;
						in_run_q <= 1'b1;
						cap_q    <= run_cap;
					end
					// mk_q holds the first segment of the current free run
					if (scan_hit) end_q <= chk_s1;
					if (!used_rdata && !in_run_q) mk_q <= chk_s1;
				end
			end
			ffsa_pkg::S_MARK: mk_q <= CNT_W'(mk_q + 1'b1);
			ffsa_pkg::S_FIND: begin
				if (!find_match) seg_addr_q <= seg_addr_q + SEG_STEP;
			end
			default: begin
			end
		endcase
	end

	assign in_ready      = state_q == ffsa_pkg::S_IDLE;
	assign cfg_ready     = 1'b1;
	assign out_valid     = out_valid_q;
	assign block_address = block_address_q;
	assign status        = status_q;

endmodule

@@ design/ffsa_flag_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffsa_flag_ram
// One-bit-wide flag store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module ffsa_flag_ram #(
	parameter int DEPTH = ffsa_pkg::NUM_SEGMENTS_DEF,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic          wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic          rdata
);

	logic mem [DEPTH];
	logic rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ test/first_fit_segment_allocator_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_segment_allocator_tb
// Self-checking bench for the first-fit segment allocator. A directed table
// covers field extremes, error codes and the odd release cases. Random phases
// follow: mostly allocate/release pairs over tracked runs, plus stray
// addresses. They run under several base/count settings and throttling mixes,
// with one long output stall. Every result is checked against a local copy of
// the segment flag tables, or against the row's own expectation where typed.
// ----------------------------------------------------------------------------
module first_fit_segment_allocator_tb;

	localparam int NUM_SEGMENTS  = ffsa_pkg::NUM_SEGMENTS_DEF;
	localparam int SEGMENT_BYTES = ffsa_pkg::SEGMENT_BYTES_DEF;
	localparam int HOLD_CYCLES   = 1500;
	localparam int QUIET_LIMIT   = 10000;
	localparam int SETTLE_CYCLES = 2 * NUM_SEGMENTS + 16;

	typedef struct packed {
		logic [ffsa_pkg::ADDR_W-1:0]   block_address;
		logic [ffsa_pkg::STATUS_W-1:0] status;
	} grant_t;

	typedef enum logic [0:0] {ROW_REQ, ROW_CFG} row_kind_t;

	// CFG rows carry data_base in addr and segment_count in seg_count
	typedef struct packed {
		row_kind_t                        kind;
		logic                             mode;
		logic [ffsa_pkg::REQ_BYTES_W-1:0] bytes;
		logic [ffsa_pkg::ADDR_W-1:0]      addr;
		logic [ffsa_pkg::SEG_COUNT_W-1:0] seg_count;
		logic                             typed;
		logic [ffsa_pkg::ADDR_W-1:0]      exp_addr;
		logic [ffsa_pkg::STATUS_W-1:0]    exp_status;
	} row_t;

	typedef struct packed {
		logic [6:0]                       src_idle;
		logic [6:0]                       sink_idle;
		logic                             rand_base;
		logic [ffsa_pkg::ADDR_W-1:0]      base;
		logic [ffsa_pkg::SEG_COUNT_W-1:0] seg_count;
		logic [10:0]                      items;
		logic                             squeeze;
	} phase_t;

	localparam row_t DIRECTED [25] = '{
		// release on an empty table walks all the way up
		'{ROW_REQ, ffsa_pkg::MODE_RELEASE, 21'd0, 32'h0000_0000, 9'd0,
			1'b1, 32'h0, ffsa_pkg::ST_OK},
		'{ROW_REQ, ffsa_pkg::MODE_ALLOC, 21'd0, 32'hFFFF_FFFF, 9'd0,
			1'b1, 32'h0000_0000, ffsa_pkg::ST_OK},
		'{ROW_REQ, ffsa_pkg::MODE_ALLOC, 21'd1, 32'h0000_0000, 9'd0,
			1'b1, 32'h0000_1000, ffsa_pkg::ST_OK},
		'{ROW_REQ, ffsa_pkg::MODE_ALLOC, 21'd4096, 32'h0, 9'd0,
			1'b1, 32'h0000_2000, ffsa_pkg::ST_OK},
		'{ROW_REQ, ffsa_pkg::MODE_ALLOC, 21'd4097, 32'h0, 9'd0,
			1'b1, 32'h0000_3000, ffsa_pkg::ST_OK},
		'{ROW_REQ, ffsa_pkg::MODE_ALLOC, 21'd1048576, 32'h0, 9'd0,
			1'b1, 32'h0, ffsa_pkg::ST_NO_SPACE},
		'{ROW_REQ, ffsa_pkg::MODE_ALLOC, 21'h1F_FFFF, 32'h0, 9'd0,
			1'b1, 32'h0, ffsa_pkg::ST_NO_SPACE},
		'{ROW_REQ, ffsa_pkg::MODE_RELEASE, 21'h1F_FFFF, 32'h0000_1000, 9'd0,
			1'b1, 32'h0, ffsa_pkg::ST_OK},
		'{ROW_REQ, ffsa_pkg::MODE_RELEASE, 21'd0, 32'h0000_1001, 9'd0,
			1'b1, 32'h0, ffsa_pkg::ST_NOT_FOUND},
		'{ROW_REQ, ffsa_pkg::MODE_RELEASE, 21'd0, 32'hFFFF_FFFF, 9'd0,
			1'b1, 32'h0, ffsa_pkg::ST_NOT_FOUND},
		'{ROW_REQ, ffsa_pkg::MODE_RELEASE, 21'd0, 32'h0010_0000, 9'd0,
			1'b1, 32'h0, ffsa_pkg::ST_NOT_FOUND},
		// last segment, free, no run end above it
		'{ROW_REQ, ffsa_pkg::MODE_RELEASE, 21'd0, 32'h000F_F000, 9'd0,
			1'b1, 32'h0, ffsa_pkg::ST_OK},
		// tail of a two-segment run, then its orphaned head
		'{ROW_REQ, ffsa_pkg::MODE_RELEASE, 21'd0, 32'h0000_4000, 9'd0,
			1'b0, 32'h0, ffsa_pkg::ST_OK},
		'{ROW_REQ, ffsa_pkg::MODE_RELEASE, 21'd0, 32'h0000_3000, 9'd0,
			1'b0, 32'h0, ffsa_pkg::ST_OK},
		'{ROW_REQ, ffsa_pkg::MODE_ALLOC, 21'd8192, 32'h0, 9'd0,
			1'b0, 32'h0, ffsa_pkg::ST_OK},
		'{ROW_REQ, ffsa_pkg::MODE_ALLOC, 21'd20000, 32'h0, 9'd0,
			1'b0, 32'h0, ffsa_pkg::ST_OK},
		'{ROW_REQ, ffsa_pkg::MODE_RELEASE, 21'd0, 32'h0000_0000, 9'd0,
			1'b0, 32'h0, ffsa_pkg::ST_OK},
		'{ROW_CFG, ffsa_pkg::MODE_ALLOC, 21'd0, 32'h0000_0000, 9'd0,
			1'b0, 32'h0, ffsa_pkg::ST_OK},
		'{ROW_REQ, ffsa_pkg::MODE_ALLOC, 21'd0, 32'h0, 9'd0,
			1'b1, 32'h0, ffsa_pkg::ST_NO_SPACE},
		'{ROW_REQ, ffsa_pkg::MODE_RELEASE, 21'd0, 32'h0000_0000, 9'd0,
			1'b1, 32'h0, ffsa_pkg::ST_NOT_FOUND},
		// count above the table saturates; base near the top wraps addresses
		'{ROW_CFG, ffsa_pkg::MODE_ALLOC, 21'd0, 32'hFFFF_F000, 9'd511,
			1'b0, 32'h0, ffsa_pkg::ST_OK},
		'{ROW_REQ, ffsa_pkg::MODE_ALLOC, 21'd12288, 32'h0, 9'd0,
			1'b0, 32'h0, ffsa_pkg::ST_OK},
		'{ROW_REQ, ffsa_pkg::MODE_RELEASE, 21'd0, 32'h0000_0000, 9'd0,
			1'b0, 32'h0, ffsa_pkg::ST_OK},
		'{ROW_REQ, ffsa_pkg::MODE_ALLOC, 21'd1048576, 32'h0, 9'd0,
			1'b0, 32'h0, ffsa_pkg::ST_OK},
		'{ROW_REQ, ffsa_pkg::MODE_RELEASE, 21'd0, 32'hFFFF_F000, 9'd0,
			1'b0, 32'h0, ffsa_pkg::ST_OK}
	};

	localparam phase_t PHASES [7] = '{
		'{7'd18, 7'd74, 1'b0, 32'h8000_0000, 9'd256, 11'd160, 1'b0},
		'{7'd18, 7'd74, 1'b0, 32'hFFFF_FFFF, 9'd16,  11'd160, 1'b0},
		'{7'd74, 7'd18, 1'b1, 32'h0000_0000, 9'd64,  11'd160, 1'b0},
		'{7'd74, 7'd18, 1'b0, 32'h0000_0000, 9'd0,   11'd40,  1'b0},
		'{7'd0,  7'd0,  1'b0, 32'h0000_0000, 9'd1,   11'd120, 1'b1},
		'{7'd0,  7'd0,  1'b1, 32'h0000_0000, 9'd511, 11'd240, 1'b0},
		'{7'd0,  7'd0,  1'b0, 32'h0000_0000, 9'd256, 11'd220, 1'b0}
	};

	logic                             clk;
	logic                             arst_n          = 1'b0;
	logic                             in_valid        = 1'b0;
	logic                             in_ready;
	logic                             mode            = ffsa_pkg::MODE_ALLOC;
	logic [ffsa_pkg::REQ_BYTES_W-1:0] request_bytes   = '0;
	logic [ffsa_pkg::ADDR_W-1:0]      release_address = '0;
	logic                             out_valid;
	logic                             out_ready       = 1'b0;
	logic [ffsa_pkg::ADDR_W-1:0]      block_address;
	logic [ffsa_pkg::STATUS_W-1:0]    status;
	logic                             cfg_valid       = 1'b0;
	logic                             cfg_ready;
	logic [ffsa_pkg::CFG_INDEX_W-1:0] cfg_index       = ffsa_pkg::REG_DATA_BASE;
	logic [ffsa_pkg::ADDR_W-1:0]      cfg_data        = '0;

	// local copy of the allocator state
	logic [ffsa_pkg::ADDR_W-1:0]      cur_base  = ffsa_pkg::DATA_BASE_RST;
	logic [ffsa_pkg::SEG_COUNT_W-1:0] cur_count = ffsa_pkg::SEG_COUNT_RST;
	bit                               seg_used [NUM_SEGMENTS];
	bit                               seg_last [NUM_SEGMENTS];

	grant_t pending_grants [$];
	int     live_runs [$];   // start segment of runs handed out
	int     mismatches    = 0;
	int     src_idle_pct  = 18;
	int     sink_idle_pct = 74;
	int     hold_left     = 0;
	bit     hold_arm      = 1'b0;
	int     quiet_cycles  = 0;

	first_fit_segment_allocator #(
		.NUM_SEGMENTS (NUM_SEGMENTS),
		.SEGMENT_BYTES(SEGMENT_BYTES)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.mode           (mode),
		.request_bytes  (request_bytes),
		.release_address(release_address),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.block_address  (block_address),
		.status         (status),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t ERROR %s: got %h, want %h", $time, what, got, want);
		mismatches++;
	endtask

	// first-fit grant or run release; updates the local flag tables
	task automatic resolve_request(input logic m,
			input logic [ffsa_pkg::REQ_BYTES_W-1:0] b,
			input logic [ffsa_pkg::ADDR_W-1:0] a, output grant_t g, output int start_idx);
		int          active;
		int          needed;
		int          run;
		int          i;
		int          k;
		bit          hit;
		logic [31:0] seg_addr;
		active = (cur_count > NUM_SEGMENTS) ? NUM_SEGMENTS : int'(cur_count);
		g = '0;
		start_idx = -1;
		hit = 1'b0;
		run = 0;
		i = 0;
		if (m == ffsa_pkg::MODE_ALLOC) begin
			needed = (int'(b) + SEGMENT_BYTES - 1) / SEGMENT_BYTES;
			if (needed == 0)
				needed = 1;
			while (i < active && !hit) begin
				if (seg_used[i]) begin
					run = 0;
				end else begin
					if (run == 0)
						start_idx = i;
					run++;
					if (run >= needed)
						hit = 1'b1;
				end
				if (!hit)
					i++;
			end
			if (hit) begin
				for (k = start_idx; k <= i; k++)
					seg_used[k] = 1'b1;
				seg_last[i] = 1'b1;
				g.block_address = cur_base + 32'(start_idx) * 32'(SEGMENT_BYTES);
				g.status = ffsa_pkg::ST_OK;
			end else begin
				start_idx = -1;
				g.status = ffsa_pkg::ST_NO_SPACE;
			end
		end else begin
			while (i < active && !hit) begin
				seg_addr = cur_base + 32'(i) * 32'(SEGMENT_BYTES);
				if (seg_addr == a)
					hit = 1'b1;
				else
					i++;
			end
			if (hit) begin
				while (i < active) begin
					seg_used[i] = 1'b0;
					if (seg_last[i]) begin
						seg_last[i] = 1'b0;
						break;
					end
					i++;
				end
				g.status = ffsa_pkg::ST_OK;
			end else begin
				g.status = ffsa_pkg::ST_NOT_FOUND;
			end
		end
	endtask

	// returns right after the edge at which the request is taken
	task automatic offer_request(input logic m, input logic [ffsa_pkg::REQ_BYTES_W-1:0] b,
			input logic [ffsa_pkg::ADDR_W-1:0] a);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid        <= 1'b1;
		mode            <= m;
		request_bytes   <= b;
		release_address <= a;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_grants.size() != 0)
			@(posedge clk);
	endtask

	// writes both registers back to back; upper count bits are don't-care
	task automatic apply_config(input logic [ffsa_pkg::ADDR_W-1:0] base,
			input logic [ffsa_pkg::SEG_COUNT_W-1:0] count);
		cfg_valid <= 1'b1;
		cfg_index <= ffsa_pkg::REG_DATA_BASE;
		cfg_data  <= base;
		do @(posedge clk); while (!cfg_ready);
		cur_base = base;
		cfg_index <= ffsa_pkg::REG_SEGMENT_COUNT;
		cfg_data  <= {23'($urandom), count};
		do @(posedge clk); while (!cfg_ready);
		cur_count = count;
		cfg_valid <= 1'b0;
	endtask

	// result side: check, then decide out_ready for the next edge
	initial begin
		grant_t want;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (pending_grants.size() == 0) begin
					report_mismatch("result with no request pending", block_address, '0);
				end else begin
					want = pending_grants.pop_front();
					if (block_address !== want.block_address)
						report_mismatch("block_address", block_address, want.block_address);
					if (status !== want.status)
						report_mismatch("status", 32'(status), 32'(want.status));
				end
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else if (hold_arm) begin
				hold_arm = 1'b0;
				hold_left = HOLD_CYCLES - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t watchdog: no handshake for %0d cycles", $time, QUIET_LIMIT);
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		grant_t                           g;
		row_t                             r;
		phase_t                           ph;
		int                               s;
		int                               n;
		int                               j;
		int                               p;
		logic                             m;
		logic [ffsa_pkg::REQ_BYTES_W-1:0] b;
		logic [ffsa_pkg::ADDR_W-1:0]      a;
		foreach (seg_used[i]) begin
			seg_used[i] = 1'b0;
			seg_last[i] = 1'b0;
		end
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED[i]) begin
			r = DIRECTED[i];
			if (r.kind == ROW_CFG) begin
				wait_idle();
				apply_config(r.addr, r.seg_count);
			end else begin
				offer_request(r.mode, r.bytes, r.addr);
				resolve_request(r.mode, r.bytes, r.addr, g, s);
				if (r.typed) begin
					g.block_address = r.exp_addr;
					g.status = r.exp_status;
				end
				pending_grants.push_back(g);
			end
		end

		for (p = 0; p < $size(PHASES); p++) begin
			ph = PHASES[p];
			wait_idle();
			apply_config(ph.rand_base ? 32'($urandom) : ph.base, ph.seg_count);
			src_idle_pct  = ph.src_idle;
			sink_idle_pct = ph.sink_idle;
			if (ph.squeeze)
				hold_arm = 1'b1;
			for (n = 0; n < ph.items; n++) begin
				if (live_runs.size() == 0
						|| $urandom_range(99) < (live_runs.size() < 6 ? 70 : 45)) begin
					m = ffsa_pkg::MODE_ALLOC;
					a = $urandom;
					case ($urandom_range(9))
						0:       b = '0;
						1:       b = 21'($urandom);
						2:       b = 21'($urandom_range(0, 1048576));
						3:       b = 21'($urandom_range(1, 8) * SEGMENT_BYTES);
						default: b = 21'($urandom_range(1, 4 * SEGMENT_BYTES));
					endcase
				end else begin
					m = ffsa_pkg::MODE_RELEASE;
					b = 21'($urandom);
					if ($urandom_range(99) < 80) begin
						j = $urandom_range(live_runs.size() - 1);
						a = cur_base + 32'(live_runs[j]) * 32'(SEGMENT_BYTES);
						live_runs.delete(j);
					end else begin
						// stray address: anywhere, any segment edge, or off an edge
						case ($urandom_range(2))
							0: a = $urandom;
							1: a = cur_base + 32'($urandom_range(0, int'(cur_count) + 1))
									* 32'(SEGMENT_BYTES);
							default: a = cur_base + 32'($urandom_range(0, int'(cur_count)))
									* 32'(SEGMENT_BYTES) + 32'($urandom_range(1, SEGMENT_BYTES - 1));
						endcase
					end
				end
				offer_request(m, b, a);
				resolve_request(m, b, a, g, s);
				pending_grants.push_back(g);
				if (m == ffsa_pkg::MODE_ALLOC && g.status == ffsa_pkg::ST_OK)
					live_runs.push_back(s);
			end
		end

		wait_idle();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
